/* hw/rtl/pscc_pkg.sv */
`default_nettype none

package pscc_pkg;

    // field widths
    localparam int TIME_BITS   = 16;
    localparam int ADC_BITS    = 10;
    localparam int SCALE_BITS  = 14;
    localparam int SCALE_SHIFT = SCALE_BITS - ADC_BITS;
    localparam int CHAN_BITS   = 5;
    localparam int CTL_BITS    = 7;
    localparam int KIND_BITS   = 2;
    localparam int NUM_PEDALS  = 4;

    // stream packing
    localparam int S_DATA_BITS = 32;
    localparam int M_DATA_BITS = 24;

    // apb
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam logic REG_CHANNEL  = 1'b0;
    localparam logic REG_DEADBAND = 1'b1;
    localparam logic [CHAN_BITS-1:0] CHANNEL_RESET  = 5'd1;
    localparam logic [ADC_BITS-1:0]  DEADBAND_RESET = 10'd7;

    // job queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    // scan steps
    localparam logic [2:0] STEP_SUSTAIN  = 3'd1;
    localparam logic [2:0] STEP_CONFIG   = 3'd2;
    localparam logic [2:0] STEP_SWITCH_A = 3'd3;
    localparam logic [2:0] STEP_ANALOG_A = 3'd4;
    localparam logic [2:0] STEP_SWITCH_B = 3'd5;
    localparam logic [2:0] STEP_ANALOG_B = 3'd6;
    localparam logic [2:0] STEP_IDLE     = 3'd0;

    // pedal bits
    localparam logic [1:0] PED_SUS = 2'd0;
    localparam logic [1:0] PED_CFG = 2'd1;
    localparam logic [1:0] PED_A   = 2'd2;
    localparam logic [1:0] PED_B   = 2'd3;

    // event kinds
    localparam logic [KIND_BITS-1:0] EV_CC         = 2'd0;
    localparam logic [KIND_BITS-1:0] EV_MENU_OPEN  = 2'd1;
    localparam logic [KIND_BITS-1:0] EV_MENU_CLOSE = 2'd2;

    // controller numbers and values
    localparam logic [CTL_BITS-1:0] CTL_SUSTAIN  = 7'd64;
    localparam logic [CTL_BITS-1:0] CTL_SWITCH_A = 7'd12;
    localparam logic [CTL_BITS-1:0] CTL_SWITCH_B = 7'd13;
    localparam logic [CTL_BITS-1:0] FINE_OFFSET  = 7'd32;
    localparam logic [CTL_BITS-1:0] VAL_ON       = 7'd64;
    localparam logic [CTL_BITS-1:0] VAL_OFF      = 7'd0;

    typedef struct packed {
        logic [CHAN_BITS-1:0] channel;
        logic [ADC_BITS-1:0]  deadband;
    } cfg_t;

    // one queued job: one or two result items
    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [CTL_BITS-1:0]  controller;
        logic [CTL_BITS-1:0]  first_value;
        logic [CTL_BITS-1:0]  fine_value;
        logic                 two;
    } job_t;

endpackage

`default_nettype wire

/* hw/rtl/pscc_cfg.sv */
`default_nettype none

module pscc_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [pscc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [pscc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [pscc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                     pready,
    output pscc_pkg::cfg_t                           cfg
);

    logic [pscc_pkg::CHAN_BITS-1:0] channel_reg;
    logic [pscc_pkg::ADC_BITS-1:0]  deadband_reg;
    logic                           reg_idx;
    logic                           wr_en;

    // register select by word address
    assign reg_idx = paddr[pscc_pkg::APB_ADDR_BITS-1];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg  <= pscc_pkg::CHANNEL_RESET;
            deadband_reg <= pscc_pkg::DEADBAND_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                pscc_pkg::REG_CHANNEL:  channel_reg  <= pwdata[pscc_pkg::CHAN_BITS-1:0];
                pscc_pkg::REG_DEADBAND: deadband_reg <= pwdata[pscc_pkg::ADC_BITS-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            pscc_pkg::REG_CHANNEL:  prdata = pscc_pkg::APB_DATA_BITS'(channel_reg);
            pscc_pkg::REG_DEADBAND: prdata = pscc_pkg::APB_DATA_BITS'(deadband_reg);
            default:                prdata = '0;
        endcase
    end

    assign cfg.channel  = channel_reg;
    assign cfg.deadband = deadband_reg;

endmodule

`default_nettype wire

/* hw/rtl/pscc_front.sv */
`default_nettype none

module pscc_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            fire,
    input  wire logic [pscc_pkg::NUM_PEDALS-1:0] pedal_pins_n,
    input  wire logic [pscc_pkg::ADC_BITS-1:0]   adc_sample,
    input  wire logic [pscc_pkg::TIME_BITS-1:0]  time_mark,
    input  wire pscc_pkg::cfg_t                  cfg,
    output logic                                 push,
    output pscc_pkg::job_t                       job
);

    logic [2:0]                           pos_reg, pos_next, step;
    logic [pscc_pkg::NUM_PEDALS-1:0]      state_reg, state_next;
    logic [pscc_pkg::NUM_PEDALS-1:0]      sampled_reg, sampled_next;
    logic [pscc_pkg::TIME_BITS-1:0]       change_time_reg [pscc_pkg::NUM_PEDALS];
    logic [pscc_pkg::ADC_BITS-1:0]        analog_last_reg [2];

    logic                                 sw_en, an_en, an_idx, sample_step;
    logic [1:0]                           ped;
    logic [pscc_pkg::CTL_BITS-1:0]        ctl;
    logic                                 sw_accept, level;
    logic [pscc_pkg::ADC_BITS-1:0]        last, delta;
    logic                                 an_report;
    logic [pscc_pkg::SCALE_BITS-1:0]      scaled;

    assign step = pos_reg + 3'd1;

    // decode the scan step
    always_comb
    begin
        sw_en       = 1'b0;
        an_en       = 1'b0;
        an_idx      = 1'b0;
        sample_step = 1'b0;
        ped         = pscc_pkg::PED_SUS;
        ctl         = pscc_pkg::CTL_SUSTAIN;
        pos_next    = step;
        case (step)
            pscc_pkg::STEP_SUSTAIN:
            begin
                sw_en = 1'b1;
            end
            pscc_pkg::STEP_CONFIG:
            begin
                sw_en = 1'b1;
                ped   = pscc_pkg::PED_CFG;
            end
            pscc_pkg::STEP_SWITCH_A:
            begin
                sw_en = 1'b1;
                ped   = pscc_pkg::PED_A;
                ctl   = pscc_pkg::CTL_SWITCH_A;
            end
            pscc_pkg::STEP_ANALOG_A:
            begin
                an_en = 1'b1;
                ctl   = pscc_pkg::CTL_SWITCH_A;
            end
            pscc_pkg::STEP_SWITCH_B:
            begin
                sw_en = 1'b1;
                ped   = pscc_pkg::PED_B;
                ctl   = pscc_pkg::CTL_SWITCH_B;
            end
            pscc_pkg::STEP_ANALOG_B:
            begin
                an_en  = 1'b1;
                an_idx = 1'b1;
                ctl    = pscc_pkg::CTL_SWITCH_B;
            end
            default:
            begin
                sample_step = 1'b1;
                pos_next    = pscc_pkg::STEP_IDLE;
            end
        endcase
    end

    // switch pedal: level differs and time mark moved since last change
    assign level     = sampled_reg[ped];
    assign sw_accept = sw_en && (time_mark != change_time_reg[ped])
                       && (state_reg[ped] != sampled_reg[ped]);

    // analog pedal: distance from last reported sample against deadband
    assign last      = analog_last_reg[an_idx];
    assign delta     = (adc_sample >= last) ? (adc_sample - last) : (last - adc_sample);
    assign an_report = an_en && (delta >= cfg.deadband);
    assign scaled    = pscc_pkg::SCALE_BITS'(adc_sample) << pscc_pkg::SCALE_SHIFT;

    // build the job
    always_comb
    begin
        job.kind        = pscc_pkg::EV_CC;
        job.controller  = ctl;
        job.first_value = level ? pscc_pkg::VAL_ON : pscc_pkg::VAL_OFF;
        job.fine_value  = scaled[pscc_pkg::CTL_BITS-1:0];
        job.two         = 1'b0;
        if (an_en)
        begin
            job.first_value = scaled[pscc_pkg::SCALE_BITS-1:pscc_pkg::CTL_BITS];
            job.two         = 1'b1;
        end
        else if (ped == pscc_pkg::PED_CFG)
        begin
            job.kind        = level ? pscc_pkg::EV_MENU_OPEN : pscc_pkg::EV_MENU_CLOSE;
            job.controller  = '0;
            job.first_value = '0;
        end
    end

    assign push = fire && (sw_accept || an_report);

    // pedal level and sampled pins
    always_comb
    begin
        state_next   = state_reg;
        sampled_next = sampled_reg;
        if (sw_accept)
        begin
            state_next[ped] = sampled_reg[ped];
        end
        if (sample_step)
        begin
            sampled_next = ~pedal_pins_n;
        end
    end

    // scan state update on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= pscc_pkg::STEP_IDLE;
            state_reg   <= '0;
            sampled_reg <= '0;
            for (int i = 0; i < pscc_pkg::NUM_PEDALS; i++)
            begin
                change_time_reg[i] <= '0;
            end
            analog_last_reg[0] <= '0;
            analog_last_reg[1] <= '0;
        end
        else if (fire)
        begin
            pos_reg     <= pos_next;
            state_reg   <= state_next;
            sampled_reg <= sampled_next;
            if (sw_accept)
            begin
                change_time_reg[ped] <= time_mark;
            end
            if (an_report)
            begin
                analog_last_reg[an_idx] <= adc_sample;
            end
        end
    end

    // scan position stays inside the seven-step cycle
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 3'd7)
        else $error("scan position left its cycle");

endmodule

`default_nettype wire

/* hw/rtl/pscc_queue.sv */
`default_nettype none

module pscc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire pscc_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output pscc_pkg::job_t      head
);

    pscc_pkg::job_t                   slot_reg [pscc_pkg::QUEUE_DEPTH];
    logic [pscc_pkg::QPTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [pscc_pkg::QCNT_BITS-1:0]   count_reg, count_next;

    assign full  = (count_reg == pscc_pkg::QCNT_BITS'(pscc_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("job popped from an empty queue");

endmodule

`default_nettype wire

/* hw/rtl/pscc_back.sv */
`default_nettype none

module pscc_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire pscc_pkg::cfg_t                  cfg,
    input  wire logic                            q_valid,
    input  wire pscc_pkg::job_t                  q_head,
    output logic                                 pop,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [pscc_pkg::KIND_BITS-1:0]       event_kind,
    output logic [pscc_pkg::CTL_BITS-1:0]        controller,
    output logic [pscc_pkg::CTL_BITS-1:0]        cc_value,
    output logic [pscc_pkg::CHAN_BITS-1:0]       midi_channel,
    output logic                                 last_of_run
);

    logic           busy_reg, busy_next;
    logic           phase_reg, phase_next;
    pscc_pkg::job_t job_reg;
    logic           out_fire;

    assign out_valid = busy_reg;
    assign out_fire  = busy_reg && out_ready;

    // result fields from the held job and its phase
    assign event_kind   = job_reg.kind;
    assign controller   = phase_reg ? (job_reg.controller + pscc_pkg::FINE_OFFSET)
                                    : job_reg.controller;
    assign cc_value     = phase_reg ? job_reg.fine_value : job_reg.first_value;
    assign midi_channel = (job_reg.kind == pscc_pkg::EV_CC) ? cfg.channel : '0;
    assign last_of_run  = !job_reg.two || phase_reg;

    // take the next job when idle or when the last item of this one leaves
    assign pop = q_valid && (!busy_reg || (out_fire && last_of_run));

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        if (out_fire && !last_of_run)
        begin
            phase_next = 1'b1;
        end
        else if (!busy_reg || out_fire)
        begin
            busy_next  = q_valid;
            phase_next = 1'b0;
        end
    end

    // output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
    end

    // held job
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_head;
        end
    end

    a_fine_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (busy_reg && job_reg.two))
        else $error("fine phase on a single-result job");

    a_coarse_then_fine: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !last_of_run) |=> (busy_reg && phase_reg))
        else $error("fine result of an analog report lost");

endmodule

`default_nettype wire

/* hw/rtl/pedal_scan_to_control_change_top.sv */
// a result is registered in a queue slot, then in the output stage's held job
// throughput: one item per cycle while the queue is not full; an analog report
// gives a coarse and a fine result, and a 4-job queue between scan logic and
// output lets the input run on; items that cause no result never enter the queue
// reset (rst_n low, async): scan position 0, pedals released, change marks and
// analog history 0, channel 1, deadband 7, queue and output empty
`default_nettype none

module pedal_scan_to_control_change_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // stream in
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // pedal_pins_n[3:0], adc_sample[13:4], time_mark[29:14], zero fill
    input  wire logic [pscc_pkg::S_DATA_BITS-1:0]    s_axis_tdata,
    // stream out
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // controller[6:0], cc_value[13:7], midi_channel[18:14], zero fill
    output logic      [pscc_pkg::M_DATA_BITS-1:0]    m_axis_tdata,
    // event_kind[1:0]
    output logic      [pscc_pkg::KIND_BITS-1:0]      m_axis_tuser,
    output logic                                     m_axis_tlast,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [pscc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [pscc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [pscc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                     pready
);

    localparam int ADC_LO  = pscc_pkg::NUM_PEDALS;
    localparam int TIME_LO = ADC_LO + pscc_pkg::ADC_BITS;
    localparam int M_USED  = 2 * pscc_pkg::CTL_BITS + pscc_pkg::CHAN_BITS;

    pscc_pkg::cfg_t                   cfg;
    pscc_pkg::job_t                   push_job, q_head;
    logic                             push, q_full, q_valid, pop, fire;
    logic [pscc_pkg::CTL_BITS-1:0]    controller, cc_value;
    logic [pscc_pkg::CHAN_BITS-1:0]   midi_channel;

    assign s_axis_tready = !q_full;
    assign fire          = s_axis_tvalid && s_axis_tready;

    pscc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pscc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .pedal_pins_n (s_axis_tdata[pscc_pkg::NUM_PEDALS-1:0]),
        .adc_sample   (s_axis_tdata[TIME_LO-1:ADC_LO]),
        .time_mark    (s_axis_tdata[TIME_LO+pscc_pkg::TIME_BITS-1:TIME_LO]),
        .cfg          (cfg),
        .push         (push),
        .job          (push_job)
    );

    pscc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    pscc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .event_kind   (m_axis_tuser),
        .controller   (controller),
        .cc_value     (cc_value),
        .midi_channel (midi_channel),
        .last_of_run  (m_axis_tlast)
    );

    // result packing
    assign m_axis_tdata = {{(pscc_pkg::M_DATA_BITS-M_USED){1'b0}},
                           midi_channel, cc_value, controller};

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

    import pscc_pkg::*;

    // one scan call as packed on s_axis_tdata, highest field first
    typedef struct packed {
        logic [TIME_BITS-1:0] tmark;
        logic [ADC_BITS-1:0]  sample;
        logic [3:0]           pins;
    } scan_item_t;

    // one control change or menu event
    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [CTL_BITS-1:0]  ctl;
        logic [CTL_BITS-1:0]  val;
        logic [CHAN_BITS-1:0] chan;
        logic                 last;
    } pedal_event_t;

    localparam int SCAN_STEPS  = 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 50000;
    localparam int SETTLE      = 8;
    localparam int MAX_PRINTS  = 50;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_CHANNEL  = {REG_CHANNEL, 2'b00};
    localparam logic [APB_ADDR_BITS-1:0] ADDR_DEADBAND = {REG_DEADBAND, 2'b00};

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [S_DATA_BITS-1:0]    s_axis_tdata  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [M_DATA_BITS-1:0]    m_axis_tdata;
    logic [KIND_BITS-1:0]      m_axis_tuser;
    logic                      m_axis_tlast;
    logic                      psel          = 1'b0;
    logic                      penable       = 1'b0;
    logic                      pwrite        = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr         = '0;
    logic [APB_DATA_BITS-1:0]  pwdata        = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    pedal_scan_to_control_change_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 clk = ~clk;

    // predictor copy of the block state and registers
    logic [2:0]           scan_pos     = STEP_IDLE;
    logic [3:0]           pedal_level  = '0;
    logic [3:0]           sampled_lvl  = '0;
    logic [TIME_BITS-1:0] change_mark [NUM_PEDALS];
    logic [ADC_BITS-1:0]  analog_prev [2];
    logic [CHAN_BITS-1:0] cfg_channel  = CHANNEL_RESET;
    logic [ADC_BITS-1:0]  cfg_deadband = DEADBAND_RESET;

    scan_item_t   scan_q[$];
    pedal_event_t expected_events[$];
    int           error_count = 0;
    int           cycle_count = 0;

    // stimulus generator state
    int                   gen_count = 0;
    logic [TIME_BITS-1:0] gen_tmark = '0;
    logic [3:0]           gen_pins  = 4'hf;
    int                   gen_sample [2];

    initial
    begin
        foreach (change_mark[i]) change_mark[i] = '0;
        foreach (analog_prev[i]) analog_prev[i] = '0;
        foreach (gen_sample[i]) gen_sample[i] = 0;
    end

    task automatic flag_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic push_event(input logic [KIND_BITS-1:0] kind, input logic [CTL_BITS-1:0] ctl,
                              input logic [CTL_BITS-1:0] val, input logic [CHAN_BITS-1:0] chan,
                              input logic last);
        pedal_event_t ev;
        ev.kind = kind;
        ev.ctl  = ctl;
        ev.val  = val;
        ev.chan = chan;
        ev.last = last;
        expected_events.push_back(ev);
    endtask

    // a pedal takes its sampled level only if it moved and the time mark moved
    function automatic logic take_change(input logic [1:0] ped, input logic [TIME_BITS-1:0] tm);
        if (tm == change_mark[ped])
            return 1'b0;
        if (pedal_level[ped] == sampled_lvl[ped])
            return 1'b0;
        pedal_level[ped] = sampled_lvl[ped];
        change_mark[ped] = tm;
        return 1'b1;
    endfunction

    task automatic switch_cc(input logic [1:0] ped, input logic [CTL_BITS-1:0] ctl,
                             input logic [TIME_BITS-1:0] tm);
        if (take_change(ped, tm))
            push_event(EV_CC, ctl, pedal_level[ped] ? VAL_ON : VAL_OFF, cfg_channel, 1'b1);
    endtask

    // coarse and fine control change once the pedal moved by at least the deadband
    task automatic analog_cc(input int idx, input logic [CTL_BITS-1:0] ctl,
                             input logic [ADC_BITS-1:0] sample);
        logic [ADC_BITS-1:0]   delta;
        logic [SCALE_BITS-1:0] scaled;
        delta = (sample >= analog_prev[idx]) ? sample - analog_prev[idx]
                                             : analog_prev[idx] - sample;
        if (delta < cfg_deadband)
            return;
        analog_prev[idx] = sample;
        scaled = SCALE_BITS'(sample) << SCALE_SHIFT;
        push_event(EV_CC, ctl, scaled[SCALE_BITS-1:7], cfg_channel, 1'b0);
        push_event(EV_CC, ctl + FINE_OFFSET, scaled[6:0], cfg_channel, 1'b1);
    endtask

    task automatic predict_scan(input scan_item_t it);
        scan_pos = scan_pos + 3'd1;
        case (scan_pos)
            STEP_SUSTAIN:  switch_cc(PED_SUS, CTL_SUSTAIN, it.tmark);
            STEP_CONFIG:
            begin
                if (take_change(PED_CFG, it.tmark))
                    push_event(pedal_level[PED_CFG] ? EV_MENU_OPEN : EV_MENU_CLOSE,
                               '0, '0, '0, 1'b1);
            end
            STEP_SWITCH_A: switch_cc(PED_A, CTL_SWITCH_A, it.tmark);
            STEP_ANALOG_A: analog_cc(0, CTL_SWITCH_A, it.sample);
            STEP_SWITCH_B: switch_cc(PED_B, CTL_SWITCH_B, it.tmark);
            STEP_ANALOG_B: analog_cc(1, CTL_SWITCH_B, it.sample);
            default:
            begin
                // sampling step: pins are active low
                sampled_lvl = ~it.pins;
                scan_pos    = STEP_IDLE;
            end
        endcase
    endtask

    // driver: bursts of items from scan_q with random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk)
    begin : drive_proc
        logic                   nxt_valid;
        logic [S_DATA_BITS-1:0] nxt_data;
        scan_item_t             it;
        nxt_valid = s_axis_tvalid;
        nxt_data  = s_axis_tdata;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_scan(scan_item_t'(s_axis_tdata[$bits(scan_item_t)-1:0]));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (scan_q.size() > 0)
                begin
                    it        = scan_q.pop_front();
                    nxt_data  = S_DATA_BITS'(it);
                    nxt_valid = 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;
    end

    // monitor: compare each accepted result with the oldest expectation
    int rx_cnt  = 0;
    int rx_mode = 0;

    always @(posedge clk)
    begin : watch_proc
        pedal_event_t exp_ev;
        logic         nxt_ready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_events.size() == 0)
                flag_mismatch($sformatf("unexpected result ctl %0d val %0d kind %0d",
                                        m_axis_tdata[6:0], m_axis_tdata[13:7], m_axis_tuser));
            else
            begin
                exp_ev = expected_events.pop_front();
                if (m_axis_tuser !== exp_ev.kind)
                    flag_mismatch($sformatf("event_kind got %0d expected %0d",
                                            m_axis_tuser, exp_ev.kind));
                if (m_axis_tdata[6:0] !== exp_ev.ctl)
                    flag_mismatch($sformatf("controller got %0d expected %0d",
                                            m_axis_tdata[6:0], exp_ev.ctl));
                if (m_axis_tdata[13:7] !== exp_ev.val)
                    flag_mismatch($sformatf("cc_value got %0d expected %0d",
                                            m_axis_tdata[13:7], exp_ev.val));
                if (m_axis_tdata[18:14] !== exp_ev.chan)
                    flag_mismatch($sformatf("midi_channel got %0d expected %0d",
                                            m_axis_tdata[18:14], exp_ev.chan));
                if (m_axis_tlast !== exp_ev.last)
                    flag_mismatch($sformatf("last_of_run got %0d expected %0d",
                                            m_axis_tlast, exp_ev.last));
            end
        end
        // receiver stall pattern, its mode redrawn at random among four
        rx_cnt++;
        if (rx_cnt % 48 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0:       nxt_ready = 1'b1;
            1:       nxt_ready = (rx_cnt % 4) != 3;
            2:       nxt_ready = 1'($urandom_range(0, 1));
            default: nxt_ready = (rx_cnt % 16) < 10;
        endcase
        m_axis_tready <= nxt_ready;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic apb_write(input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [APB_DATA_BITS-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_CHANNEL)
            cfg_channel = data[CHAN_BITS-1:0];
        else
            cfg_deadband = data[ADC_BITS-1:0];
    endtask

    task automatic add_scan(input logic [3:0] pins, input logic [ADC_BITS-1:0] sample,
                            input logic [TIME_BITS-1:0] tmark);
        scan_item_t it;
        it.pins   = pins;
        it.sample = sample;
        it.tmark  = tmark;
        scan_q.push_back(it);
        gen_count++;
    endtask

    // mostly well-formed scan rounds: slow clock, walking analog pedals
    task automatic gen_random(input int n);
        logic [3:0]          pins;
        logic [ADC_BITS-1:0] sample;
        int                  step, idx, r, db, w, s;
        repeat (n)
        begin
            step   = gen_count % SCAN_STEPS + 1;
            pins   = 4'($urandom_range(0, 15));
            sample = ADC_BITS'($urandom_range(0, 1023));
            r = $urandom_range(0, 99);
            if (r >= 97)
                gen_tmark = TIME_BITS'($urandom_range(0, 65535));
            else if (r >= 88)
                gen_tmark = gen_tmark + TIME_BITS'($urandom_range(2, 40));
            else if (r >= 45)
                gen_tmark = gen_tmark + 1'b1;
            if ($urandom_range(0, 99) >= 8)
            begin
                if (step == SCAN_STEPS)
                begin
                    if ($urandom_range(0, 2) == 0)
                        gen_pins = 4'($urandom_range(0, 15));
                    pins = gen_pins;
                end
                else if (step == int'(STEP_ANALOG_A) || step == int'(STEP_ANALOG_B))
                begin
                    idx = (step == int'(STEP_ANALOG_B)) ? 1 : 0;
                    db  = cfg_deadband;
                    r   = $urandom_range(0, 99);
                    if (r < 55)
                    begin
                        w = 2 * db + 3;
                        s = gen_sample[idx] + int'($urandom_range(0, 2 * w)) - w;
                    end
                    else if (r < 75)
                    begin
                        // right at the deadband edge or one short of it
                        w = db - int'($urandom_range(0, 1));
                        s = $urandom_range(0, 1) ? gen_sample[idx] + w : gen_sample[idx] - w;
                    end
                    else if (r < 87)
                        s = $urandom_range(0, 1) ? 1023 : 0;
                    else
                        s = $urandom_range(0, 1023);
                    if (s < 0)
                        s = 0;
                    if (s > 1023)
                        s = 1023;
                    sample = ADC_BITS'(s);
                    gen_sample[idx] = s;
                end
            end
            add_scan(pins, sample, gen_tmark);
        end
    endtask

    // wait for the input side and the result stream to go quiet
    task automatic drain_all();
        int waited;
        waited = 0;
        while ((scan_q.size() != 0 || s_axis_tvalid || expected_events.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    logic [CHAN_BITS-1:0] phase_channel  [5];
    logic [ADC_BITS-1:0]  phase_deadband [5];

    initial
    begin : main_seq
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // round 1: nothing pressed yet, analog A jumps to full scale
        add_scan(4'hf, 10'd0,    16'd0);
        add_scan(4'hf, 10'd0,    16'd0);
        add_scan(4'hf, 10'd0,    16'd0);
        add_scan(4'hf, 10'd1023, 16'd0);
        add_scan(4'hf, 10'd0,    16'd0);
        add_scan(4'hf, 10'd0,    16'd0);
        add_scan(4'h0, 10'd0,    16'd0);
        // round 2: all pressed; sustain refused at mark zero, deadband edge on A
        add_scan(4'h0, 10'd0,    16'd0);
        add_scan(4'h0, 10'd0,    16'd5);
        add_scan(4'h0, 10'd0,    16'd5);
        add_scan(4'h0, 10'd1016, 16'd5);
        add_scan(4'h0, 10'd0,    16'hffff);
        add_scan(4'h0, 10'd6,    16'hffff);
        add_scan(4'hf, 10'd0,    16'hffff);
        // round 3: all released; config and B refused on unchanged mark
        add_scan(4'hf, 10'd0,    16'd1);
        add_scan(4'hf, 10'd0,    16'd5);
        add_scan(4'hf, 10'd0,    16'd6);
        add_scan(4'hf, 10'd1010, 16'd6);
        add_scan(4'hf, 10'd0,    16'hffff);
        add_scan(4'hf, 10'd7,    16'hffff);
        add_scan(4'he, 10'd0,    16'hffff);
        // round 4: sustain press, menu close
        add_scan(4'he, 10'd0,    16'd1);
        add_scan(4'he, 10'd0,    16'd6);
        gen_tmark = 16'd6;
        gen_random(205);

        // register settings, extremes included
        phase_channel[0]  = 5'd16;
        phase_deadband[0] = 10'd0;
        phase_channel[1]  = 5'd0;
        phase_deadband[1] = 10'd1023;
        phase_channel[2]  = 5'd31;
        phase_deadband[2] = 10'd1;
        phase_channel[3]  = 5'($urandom_range(1, 16));
        phase_deadband[3] = 10'($urandom_range(2, 64));
        phase_channel[4]  = CHANNEL_RESET;
        phase_deadband[4] = DEADBAND_RESET;
        for (int p = 0; p < 5; p++)
        begin
            drain_all();
            apb_write(ADDR_CHANNEL, APB_DATA_BITS'(phase_channel[p]));
            apb_write(ADDR_DEADBAND, APB_DATA_BITS'(phase_deadband[p]));
            @(negedge clk);
            gen_random(225);
        end

        drain_all();
        if (expected_events.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    expected_events.size()));
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
